@@ rtl/core/sed_pkg.sv @@
// ----------------------------------------------------------------------------
// sed_pkg
// Types shared by the string edit distance block: request structs and the
// control word carried along the cell chain.
// ----------------------------------------------------------------------------
package sed_pkg;

	localparam int SYM_W  = 8;
	localparam int DIST_W = 7;

	typedef enum logic {
		PHASE_TARGET = 1'b0,
		PHASE_SOURCE = 1'b1
	} phase_t;

	typedef struct packed {
		logic             which_string;
		logic [SYM_W-1:0] symbol;
		logic             has_symbol;
		logic             last;
	} item_t;

	typedef struct packed {
		logic [DIST_W-1:0] edit_distance;
		logic              too_long;
	} result_t;

	// control word of one token in the chain
	typedef struct packed {
		logic vld;   // token present
		logic wr;    // target symbol write, idx = position
		logic init;  // target closed, seed row zero
		logic upd;   // source symbol, compute one row
		logic last;  // source closed, idx = target length
		logic ovf;   // a string overflowed
	} tok_ctl_t;

endpackage

@@ rtl/core/sed_cell.sv @@
// ----------------------------------------------------------------------------
// sed_cell
// One column of the alignment table: holds a target symbol and the column's
// last two table entries, computes one entry per source token and passes the
// token to the next column.
// ----------------------------------------------------------------------------
module sed_cell #(
	parameter int MAX_LEN = 64,
	parameter int POS = 1,
	localparam int CW = $clog2(MAX_LEN + 1)
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sed_pkg::tok_ctl_t left_ctl,
	input  logic [7:0]       left_sym,
	input  logic [7:0]       left_tsym,
	input  logic [CW-1:0]    left_val,
	input  logic [CW-1:0]    left_diag,
	input  logic [CW-1:0]    left_idx,
	input  logic [CW-1:0]    left_res,
	output sed_pkg::tok_ctl_t right_ctl,
	output logic [7:0]       right_sym,
	output logic [7:0]       right_tsym,
	output logic [CW-1:0]    right_val,
	output logic [CW-1:0]    right_diag,
	output logic [CW-1:0]    right_idx,
	output logic [CW-1:0]    right_res
);
	import sed_pkg::*;

	logic [7:0]    t_q, ps_q;
	logic [CW-1:0] up_q, dg_q, odg_q;
	logic          seen_q;
	tok_ctl_t      ctl_q;
	logic [7:0]    sym_q, tsym_q;
	logic [CW-1:0] val_q, diag_q, idx_q, res_q;

	logic [CW:0]   del_c, ins_c, sub_c, tr_c, best;
	logic          trans, hit_wr, hit_res;
	logic [CW-1:0] new_d;

	always_comb begin
		del_c  = (CW+1)'(up_q) + (CW+1)'(1);
		ins_c  = (CW+1)'(left_val) + (CW+1)'(1);
		sub_c  = (CW+1)'(dg_q) + (CW+1)'(left_sym != t_q);
		tr_c   = (CW+1)'(odg_q) + (CW+1)'(1);
		trans  = (POS > 1) && seen_q && (left_sym == left_tsym) && (ps_q == t_q);
		best   = (del_c < ins_c) ? del_c : ins_c;
		best   = (sub_c < best) ? sub_c : best;
		if (trans && (tr_c < best)) begin
			best = tr_c;
		end
		new_d   = best[CW-1:0];
		hit_wr  = left_ctl.wr && (left_idx == CW'(POS - 1));
		hit_res = left_ctl.last && (left_idx == CW'(POS));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_q  <= '0;
			seen_q <= 1'b0;
		end else begin
			ctl_q <= left_ctl;
			if (left_ctl.init) begin
				seen_q <= 1'b0;
			end else if (left_ctl.upd) begin
				seen_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (hit_wr) begin
			t_q <= left_sym;
		end
		if (left_ctl.init) begin
			up_q <= CW'(POS);
			dg_q <= CW'(POS - 1);
		end else if (left_ctl.upd) begin
			up_q  <= new_d;
			dg_q  <= left_val;
			odg_q <= left_diag;
			ps_q  <= left_sym;
		end
		sym_q  <= left_sym;
		tsym_q <= t_q;
		val_q  <= new_d;
		diag_q <= dg_q;
		idx_q  <= left_idx;
		res_q  <= hit_res ? (left_ctl.upd ? new_d : up_q) : left_res;
	end

	assign right_ctl  = ctl_q;
	assign right_sym  = sym_q;
	assign right_tsym = tsym_q;
	assign right_val  = val_q;
	assign right_diag = diag_q;
	assign right_idx  = idx_q;
	assign right_res  = res_q;

endmodule

@@ rtl/core/sed_ctrl.sv @@
// ----------------------------------------------------------------------------
// sed_ctrl
// Request intake: tracks phase, string lengths and overflow, and turns each
// accepted request into a token at the head of the cell chain.
// ----------------------------------------------------------------------------
module sed_ctrl #(
	parameter int MAX_LEN = 64,
	localparam int CW = $clog2(MAX_LEN + 1)
) (
	input  logic              clk,
	input  logic              arst_n,
	input  sed_pkg::item_t    item,
	input  logic              item_valid,
	output logic              item_stall,
	input  logic              done,
	output sed_pkg::tok_ctl_t ctl,
	output logic [7:0]        sym,
	output logic [CW-1:0]     val,
	output logic [CW-1:0]     idx,
	output logic [CW-1:0]     res
);
	import sed_pkg::*;

	phase_t        phase_q, phase_n;
	logic [CW-1:0] tcnt_q, tcnt_n, scnt_q, scnt_n;
	logic          ovf_q, ovf_n, pend_q, pend_n;
	tok_ctl_t      ctl_q, ctl_n;
	logic [7:0]    sym_q;
	logic [CW-1:0] val_q, val_n, idx_q, idx_n, res_q, res_n;
	logic          take, room_t, room_s;

	assign item_stall = pend_q && (phase_q == PHASE_SOURCE);
	assign take   = item_valid && !item_stall && (item.which_string == phase_q);
	assign room_t = tcnt_q < CW'(MAX_LEN);
	assign room_s = scnt_q < CW'(MAX_LEN);

	always_comb begin
		phase_n = phase_q;
		tcnt_n  = tcnt_q;
		scnt_n  = scnt_q;
		ovf_n   = ovf_q;
		pend_n  = pend_q && !done;
		ctl_n   = '0;
		val_n   = scnt_q + CW'(1);
		idx_n   = tcnt_q;
		res_n   = scnt_q;
		if (take) begin
			case (phase_q)
				PHASE_TARGET: begin
					ctl_n.wr   = item.has_symbol && room_t;
					ctl_n.init = item.last;
					if (item.has_symbol && room_t) begin
						tcnt_n = tcnt_q + CW'(1);
					end
					if (item.has_symbol && !room_t) begin
						ovf_n = 1'b1;
					end
					if (item.last) begin
						phase_n = PHASE_SOURCE;
						scnt_n  = '0;
					end
				end
				PHASE_SOURCE: begin
					ctl_n.upd  = item.has_symbol && room_s;
					ctl_n.last = item.last;
					ctl_n.ovf  = ovf_q || (item.has_symbol && !room_s);
					if (item.has_symbol && room_s) begin
						scnt_n = scnt_q + CW'(1);
						res_n  = scnt_q + CW'(1);
					end
					if (item.has_symbol && !room_s) begin
						ovf_n = 1'b1;
					end
					if (item.last) begin
						phase_n = PHASE_TARGET;
						tcnt_n  = '0;
						scnt_n  = '0;
						ovf_n   = 1'b0;
						pend_n  = 1'b1;
					end
				end
				default: begin
					phase_n = PHASE_TARGET;
				end
			endcase
			ctl_n.vld = ctl_n.wr || ctl_n.init || ctl_n.upd || ctl_n.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PHASE_TARGET;
			tcnt_q  <= '0;
			scnt_q  <= '0;
			ovf_q   <= 1'b0;
			pend_q  <= 1'b0;
			ctl_q   <= '0;
		end else begin
			phase_q <= phase_n;
			tcnt_q  <= tcnt_n;
			scnt_q  <= scnt_n;
			ovf_q   <= ovf_n;
			pend_q  <= pend_n;
			ctl_q   <= ctl_n;
		end
	end

	always_ff @(posedge clk) begin
		sym_q <= item.symbol;
		val_q <= val_n;
		idx_q <= idx_n;
		res_q <= res_n;
	end

	assign ctl = ctl_q;
	assign sym = sym_q;
	assign val = val_q;
	assign idx = idx_q;
	assign res = res_q;

endmodule

@@ rtl/core/string_edit_distance_top.sv @@
// ----------------------------------------------------------------------------
// string_edit_distance_top
// Optimal string alignment distance between a target and a source string.
//
// Requests arrive on item / item_valid / item_stall, one symbol each: first
// the target string (which_string = 0), closed by last, then the source
// (which_string = 1), closed by last. has_symbol = 0 closes an empty string.
// Requests of the wrong string for the current phase are taken and ignored.
// A row of MAX_LEN cells holds the target, one symbol per cell; each source
// symbol travels down the row, one cell per cycle, updating one column each.
// Throughput is one request per cycle while item_stall is low.
// The result appears on result / result_valid once the closing source request
// has passed the control register and the whole cell row. Target loading
// of the next pair proceeds meanwhile; source requests stall while a result is
// in flight or held. A held result stays stable while result_stall is high.
// Strings longer than MAX_LEN set too_long with edit_distance 0.
// Reset clears all control state; no clearing pass is needed.
// ----------------------------------------------------------------------------
module string_edit_distance_top #(
	parameter int MAX_LEN = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  sed_pkg::item_t   item,
	input  logic             item_valid,
	output logic             item_stall,
	output sed_pkg::result_t result,
	output logic             result_valid,
	input  logic             result_stall
);
	import sed_pkg::*;

	localparam int CW = $clog2(MAX_LEN + 1);

	tok_ctl_t      c_ctl  [MAX_LEN+1];
	logic [7:0]    c_sym  [MAX_LEN+1];
	logic [7:0]    c_tsym [MAX_LEN+1];
	logic [CW-1:0] c_val  [MAX_LEN+1];
	logic [CW-1:0] c_diag [MAX_LEN+1];
	logic [CW-1:0] c_idx  [MAX_LEN+1];
	logic [CW-1:0] c_res  [MAX_LEN+1];

	logic    out_vld_q, done;
	result_t out_q;
	logic    fin;

	assign done = out_vld_q && !result_stall;

	sed_ctrl #(.MAX_LEN(MAX_LEN)) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item       (item),
		.item_valid (item_valid),
		.item_stall (item_stall),
		.done       (done),
		.ctl        (c_ctl[0]),
		.sym        (c_sym[0]),
		.val        (c_val[0]),
		.idx        (c_idx[0]),
		.res        (c_res[0])
	);

	assign c_tsym[0] = '0;
	assign c_diag[0] = '0;

	for (genvar g = 1; g <= MAX_LEN; g++) begin : g_cell
		sed_cell #(.MAX_LEN(MAX_LEN), .POS(g)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.left_ctl   (c_ctl[g-1]),
			.left_sym   (c_sym[g-1]),
			.left_tsym  (c_tsym[g-1]),
			.left_val   (c_val[g-1]),
			.left_diag  (c_diag[g-1]),
			.left_idx   (c_idx[g-1]),
			.left_res   (c_res[g-1]),
			.right_ctl  (c_ctl[g]),
			.right_sym  (c_sym[g]),
			.right_tsym (c_tsym[g]),
			.right_val  (c_val[g]),
			.right_diag (c_diag[g]),
			.right_idx  (c_idx[g]),
			.right_res  (c_res[g])
		);
	end

	assign fin = c_ctl[MAX_LEN].vld && c_ctl[MAX_LEN].last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (fin) begin
			out_vld_q <= 1'b1;
		end else if (done) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (fin) begin
			out_q.too_long      <= c_ctl[MAX_LEN].ovf;
			out_q.edit_distance <= c_ctl[MAX_LEN].ovf ? '0 : DIST_W'(c_res[MAX_LEN]);
		end
	end

	assign result       = out_q;
	assign result_valid = out_vld_q;

	// a finished token never meets an occupied output register
	a_no_collide: assert property (@(posedge clk) disable iff (!arst_n)
		fin |-> !out_vld_q)
		else $error("result token arrived while a result was held");

	a_rise_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(fin))
		else $error("result_valid rose without a finished token");

	a_long_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result.too_long) |-> (result.edit_distance == '0))
		else $error("too_long result with nonzero distance");

	a_hold_stable: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && result_stall) |=> (result_valid && $stable(result)))
		else $error("held result changed while stalled");

endmodule
